FILE: rtl/core/tta_pkg.sv
package tta_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DIMS_DEF     = 4;
    localparam int DIM_WIDTH_DEF    = 12;
    localparam int OFFSET_WIDTH_DEF = 24;

    // Number of input shape registers (perm selects among these axes)
    localparam int NUM_SHAPES = 4;

    // Register field widths
    localparam int RANK_W     = 3;
    localparam int SHAPE_W    = 13;
    localparam int PERM_W     = 8;
    localparam int AXIS_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Register reset values
    localparam logic [RANK_W-1:0]  RANK_RST  = RANK_W'(1);
    localparam logic [SHAPE_W-1:0] SHAPE_RST = SHAPE_W'(1);
    localparam logic [PERM_W-1:0]  PERM_RST  = PERM_W'(228);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANK    = 3'd0,
        REG_SHAPE_0 = 3'd1,
        REG_SHAPE_1 = 3'd2,
        REG_SHAPE_2 = 3'd3,
        REG_SHAPE_3 = 3'd4,
        REG_PERM    = 3'd5
    } cfg_reg_t;

    // Status from the configuration block to the address pipeline
    typedef struct packed {
        logic              busy;      // derived strides being recomputed
        logic              size_err;  // element count exceeds offset range
        logic [RANK_W-1:0] rank;      // effective rank
    } tta_status_t;

endpackage

FILE: rtl/core/tta_cfg.sv
module tta_cfg import tta_pkg::*; #(
    parameter int MAX_DIMS     = MAX_DIMS_DEF,
    parameter int DIM_WIDTH    = DIM_WIDTH_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output tta_status_t           status,
    output logic [DIM_WIDTH:0]    ext_out    [MAX_DIMS],
    output logic [OFFSET_WIDTH-1:0] stride_out [MAX_DIMS]
);

    localparam int EW  = DIM_WIDTH + 1;
    localparam int CW  = (EW > SHAPE_W) ? EW : SHAPE_W;
    localparam int PW  = OFFSET_WIDTH + 2;
    localparam int MW  = PW + EW;
    localparam int SW  = $clog2(NUM_SHAPES + 1);
    localparam int AW  = $clog2(NUM_SHAPES);
    localparam int LIM = (MAX_DIMS < NUM_SHAPES) ? MAX_DIMS : NUM_SHAPES;
    localparam logic [PW-1:0] ONE_PW = PW'(1);
    localparam logic [PW-1:0] RANGE  = ONE_PW << OFFSET_WIDTH;
    localparam logic [PW-1:0] CAP    = RANGE + ONE_PW;
    localparam logic [CW-1:0] EXT_MAX = CW'(1) << DIM_WIDTH;

    logic [RANK_W-1:0]       rank_reg;
    logic [SHAPE_W-1:0]      shape_reg [NUM_SHAPES];
    logic [PERM_W-1:0]       perm_reg;
    logic [SW-1:0]           step_reg;
    logic [PW-1:0]           n_reg;
    logic [PW-1:0]           total_reg;
    logic [OFFSET_WIDTH-1:0] stride_reg [NUM_SHAPES];

    logic [RANK_W-1:0] eff_rank;
    logic [EW-1:0]     ext_in   [NUM_SHAPES];
    logic [EW-1:0]     ext_perm [NUM_SHAPES];
    logic [OFFSET_WIDTH-1:0] stride_perm [NUM_SHAPES];
    logic              busy;
    logic [AW-1:0]     axis_sel;
    logic [AW-1:0]     dim_sel;
    logic [MW-1:0]     prod_n;
    logic [MW-1:0]     prod_t;
    logic [PW-1:0]     n_sat;
    logic [PW-1:0]     t_sat;

    assign cfg_ready = 1'b1;

    // Register writes; a write restarts the stride derivation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg <= RANK_RST;
            for (int a = 0; a < NUM_SHAPES; a++) begin
                shape_reg[a] <= SHAPE_RST;
            end
            perm_reg <= PERM_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_RANK:    rank_reg     <= cfg_data[RANK_W-1:0];
                REG_SHAPE_0: shape_reg[0] <= cfg_data[SHAPE_W-1:0];
                REG_SHAPE_1: shape_reg[1] <= cfg_data[SHAPE_W-1:0];
                REG_SHAPE_2: shape_reg[2] <= cfg_data[SHAPE_W-1:0];
                REG_SHAPE_3: shape_reg[3] <= cfg_data[SHAPE_W-1:0];
                REG_PERM:    perm_reg     <= cfg_data[PERM_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective rank: zero acts as one, clamp to the supported dimensions
    always_comb begin
        eff_rank = rank_reg;
        if (eff_rank == '0) eff_rank = RANK_W'(1);
        if (eff_rank > RANK_W'(LIM)) eff_rank = RANK_W'(LIM);
    end

    // Clamped input extents; axes outside the rank have extent one
    always_comb begin
        logic [CW-1:0] e;
        for (int a = 0; a < NUM_SHAPES; a++) begin
            e = CW'(shape_reg[a]);
            if (e == '0) e = CW'(1);
            if (e > EXT_MAX) e = EXT_MAX;
            ext_in[a] = (RANK_W'(a) < eff_rank) ? EW'(e) : EW'(1);
        end
    end

    // Permuted extents and strides per output dimension
    always_comb begin
        logic [AXIS_W-1:0] ax;
        for (int k = 0; k < NUM_SHAPES; k++) begin
            ax = perm_reg[AXIS_W*k +: AXIS_W];
            if (RANK_W'(k) < eff_rank) begin
                ext_perm[k]    = ext_in[ax];
                stride_perm[k] = stride_reg[ax];
            end else begin
                ext_perm[k]    = EW'(1);
                stride_perm[k] = '0;
            end
        end
    end

    for (genvar i = 0; i < MAX_DIMS; i++) begin : g_dim
        if (i < NUM_SHAPES) begin : g_used
            assign ext_out[i]    = ext_perm[i];
            assign stride_out[i] = stride_perm[i];
        end else begin : g_unused
            assign ext_out[i]    = EW'(1);
            assign stride_out[i] = '0;
        end
    end

    // Derivation sequencer: one input axis (innermost first) and one
    // output dimension per cycle; strides wrap at the offset width,
    // the element count saturates
    assign busy     = (step_reg != SW'(NUM_SHAPES));
    assign axis_sel = AW'(NUM_SHAPES - 1) - step_reg[AW-1:0];
    assign dim_sel  = step_reg[AW-1:0];
    assign prod_n   = MW'(n_reg) * MW'(ext_in[axis_sel]);
    assign prod_t   = MW'(total_reg) * MW'(ext_perm[dim_sel]);
    assign n_sat    = PW'(prod_n[OFFSET_WIDTH-1:0]);
    assign t_sat    = (prod_t > MW'(CAP)) ? CAP : prod_t[PW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn || (cfg_valid && cfg_ready)) begin
            step_reg  <= '0;
            n_reg     <= ONE_PW;
            total_reg <= ONE_PW;
        end else if (busy) begin
            step_reg <= step_reg + SW'(1);
            if (RANK_W'(axis_sel) < eff_rank) begin
                n_reg <= n_sat;
            end
            if (RANK_W'(dim_sel) < eff_rank) begin
                total_reg <= t_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy) begin
            stride_reg[axis_sel] <= (RANK_W'(axis_sel) < eff_rank) ?
                                    n_reg[OFFSET_WIDTH-1:0] : '0;
        end
    end

    assign status.busy     = busy;
    assign status.size_err = (total_reg > RANGE);
    assign status.rank     = eff_rank;

endmodule

FILE: rtl/core/tensor_transpose_address_gen.sv
// Channel | Ports                                        | Direction
// --------+----------------------------------------------+----------
// request | s_valid, s_ready, s_restart                  | in
// result  | m_valid, m_ready, m_src_offset, m_dst_offset,| out
//         | m_last, m_size_error                         |
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data    | in
//
// One request per cycle in steady state unless m_ready stalls the results;
// each request passes the counter stage, per-dimension multiply and offset
// sum before its result appears. After reset and after every configuration
// write, strides are derived one multiply step per cycle; s_ready is low then.
// Reset is synchronous, active low; the walk restarts at element zero.
// A stalled result holds the pipeline; each stage advances when the next
// one is empty or moving, so no transaction is dropped.
module tensor_transpose_address_gen import tta_pkg::*; #(
    parameter int MAX_DIMS     = MAX_DIMS_DEF,
    parameter int DIM_WIDTH    = DIM_WIDTH_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_restart,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [OFFSET_WIDTH-1:0] m_src_offset,
    output logic [OFFSET_WIDTH-1:0] m_dst_offset,
    output logic                    m_last,
    output logic                    m_size_error,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int EW = DIM_WIDTH + 1;
    localparam int OW = OFFSET_WIDTH;
    localparam int MW = OW + DIM_WIDTH;

    tta_status_t   status;
    logic [EW-1:0] ext_out    [MAX_DIMS];
    logic [OW-1:0] stride_out [MAX_DIMS];

    tta_cfg #(
        .MAX_DIMS     (MAX_DIMS),
        .DIM_WIDTH    (DIM_WIDTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .status     (status),
        .ext_out    (ext_out),
        .stride_out (stride_out)
    );

    // Walk state
    logic [DIM_WIDTH-1:0] idx_reg [MAX_DIMS];
    logic [OW-1:0]        cnt_reg;

    // Stage A: counters of the current element
    logic                 a_valid_reg;
    logic [DIM_WIDTH-1:0] a_idx_reg [MAX_DIMS];
    logic [OW-1:0]        a_dst_reg;
    logic                 a_last_reg;
    logic                 a_err_reg;

    // Stage B: per-dimension products
    logic          b_valid_reg;
    logic [OW-1:0] b_prod_reg [MAX_DIMS];
    logic [OW-1:0] b_dst_reg;
    logic          b_last_reg;
    logic          b_err_reg;

    // Output register
    logic          m_valid_reg;
    logic [OW-1:0] m_src_reg;
    logic [OW-1:0] m_dst_reg;
    logic          m_last_reg;
    logic          m_err_reg;

    logic c_ready, b_ready, a_ready, s_accept;

    // Pipeline flow control
    assign c_ready  = !m_valid_reg || m_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_ready  = a_ready && !status.busy;
    assign s_accept = s_valid && s_ready;

    // Current element, last detection and carry-chained advance
    logic [DIM_WIDTH-1:0] idx_cur [MAX_DIMS];
    logic [DIM_WIDTH-1:0] idx_upd [MAX_DIMS];
    logic [OW-1:0]        cnt_cur;
    logic [OW-1:0]        cnt_upd;
    logic                 last_w;

    always_comb begin
        logic carry;
        cnt_cur = s_restart ? '0 : cnt_reg;
        last_w  = 1'b1;
        for (int i = 0; i < MAX_DIMS; i++) begin
            idx_cur[i] = s_restart ? '0 : idx_reg[i];
            if ((RANK_W'(i) < status.rank) &&
                ((EW'(idx_cur[i]) + EW'(1)) < ext_out[i])) begin
                last_w = 1'b0;
            end
        end
        carry = 1'b1;
        for (int i = MAX_DIMS - 1; i >= 0; i--) begin
            idx_upd[i] = idx_cur[i];
            if (carry && (RANK_W'(i) < status.rank)) begin
                if ((EW'(idx_cur[i]) + EW'(1)) >= ext_out[i]) begin
                    idx_upd[i] = '0;
                end else begin
                    idx_upd[i] = idx_cur[i] + DIM_WIDTH'(1);
                    carry      = 1'b0;
                end
            end
        end
        cnt_upd = cnt_cur + OW'(1);
        if (last_w || status.size_err) begin
            for (int i = 0; i < MAX_DIMS; i++) begin
                idx_upd[i] = '0;
            end
            cnt_upd = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_DIMS; i++) begin
                idx_reg[i] <= '0;
            end
            cnt_reg <= '0;
        end else if (s_accept) begin
            idx_reg <= idx_upd;
            cnt_reg <= cnt_upd;
        end
    end

    // Stage A registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int i = 0; i < MAX_DIMS; i++) begin
                a_idx_reg[i] <= status.size_err ? '0 : idx_cur[i];
            end
            a_dst_reg  <= status.size_err ? '0 : cnt_cur;
            a_last_reg <= last_w || status.size_err;
            a_err_reg  <= status.size_err;
        end
    end

    // Stage B: one multiplier per dimension
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic [MW-1:0] p;
        if (b_ready && a_valid_reg) begin
            for (int i = 0; i < MAX_DIMS; i++) begin
                p = MW'(stride_out[i]) * MW'(a_idx_reg[i]);
                b_prod_reg[i] <= p[OW-1:0];
            end
            b_dst_reg  <= a_dst_reg;
            b_last_reg <= a_last_reg;
            b_err_reg  <= a_err_reg;
        end
    end

    // Output stage: sum of products, modulo the offset range
    logic [OW-1:0] src_sum;

    always_comb begin
        src_sum = '0;
        for (int i = 0; i < MAX_DIMS; i++) begin
            src_sum = src_sum + b_prod_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (c_ready) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready && b_valid_reg) begin
            m_src_reg  <= src_sum;
            m_dst_reg  <= b_dst_reg;
            m_last_reg <= b_last_reg;
            m_err_reg  <= b_err_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_src_offset = m_src_reg;
    assign m_dst_offset = m_dst_reg;
    assign m_last       = m_last_reg;
    assign m_size_error = m_err_reg;

    // Checks
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_size_error) |->
            (m_src_offset == '0 && m_dst_offset == '0 && m_last))
        else $error("size error result with nonzero offsets or no last");

    a_restart_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_restart) |=> (a_dst_reg == '0))
        else $error("restart did not yield element zero");

    a_cfg_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |=> !s_ready)
        else $error("request accepted before strides were derived");

    a_last_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (last_w || status.size_err)) |=> (cnt_reg == '0))
        else $error("walk did not wrap after the last element");

endmodule
